### src/hbd_pkg.sv
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared types and fixed field widths of the prefix-code bitstream decoder.
// ----------------------------------------------------------------------------
package hbd_pkg;

  localparam int KIND_W  = 1;
  localparam int INDEX_W = 6;
  localparam int CODE_W  = 16;
  localparam int LEN_W   = 5;
  localparam int SYM_W   = 8;
  localparam int COUNT_W = 32;

  localparam logic [LEN_W-1:0] ERR_LEN_RESET = LEN_W'(16);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 1'b0,
    KIND_BIT  = 1'b1
  } kind_t;

  // lookup answer from the code table
  typedef struct packed {
    logic             hit;
    logic [SYM_W-1:0] symbol;
  } match_t;

  // one result request
  typedef struct packed {
    logic               symbol_valid;
    logic [SYM_W-1:0]   symbol;
    logic               error_mark;
    logic [COUNT_W-1:0] decoded_count;
  } result_t;

endpackage

### src/hbd_table.sv
// ----------------------------------------------------------------------------
// hbd_table
// Code table held in registers; every entry compares against the bit buffer
// in parallel and the lowest matching slot supplies its symbol.
// ----------------------------------------------------------------------------
module hbd_table #(
  parameter int TABLE_DEPTH   = 64,
  parameter int MAX_CODE_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     wr_en,
  input  logic [hbd_pkg::INDEX_W-1:0]              wr_index,
  input  logic [hbd_pkg::CODE_W-1:0]               wr_code,
  input  logic [hbd_pkg::LEN_W-1:0]                wr_length,
  input  logic [hbd_pkg::SYM_W-1:0]                wr_symbol,
  input  logic [MAX_CODE_BITS-1:0]                 look_buf,
  input  logic [$clog2(MAX_CODE_BITS+1)-1:0]       look_len,
  output hbd_pkg::match_t                          match
);
  import hbd_pkg::*;

  localparam int LW = $clog2(MAX_CODE_BITS + 1);
  localparam int CW = (LW > LEN_W) ? LW : LEN_W;

  logic [CODE_W-1:0]        code_r [TABLE_DEPTH];
  logic [LEN_W-1:0]         len_r  [TABLE_DEPTH];
  logic [SYM_W-1:0]         sym_r  [TABLE_DEPTH];
  logic [MAX_CODE_BITS-1:0] mask;
  logic [TABLE_DEPTH-1:0]   hit;
  logic [TABLE_DEPTH-1:0]   first;
  logic [SYM_W-1:0]         sym_sel;

  // lengths double as valid marks: zero means empty
  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!rst_n) begin
        len_r[i] <= '0;
      end else if (wr_en && (32'(wr_index) == 32'(i))) begin
        len_r[i] <= wr_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (wr_en && (32'(wr_index) == 32'(i))) begin
        code_r[i] <= wr_code;
        sym_r[i]  <= wr_symbol;
      end
    end
  end

  // one mask shared by all entries, since a hit needs equal lengths
  always_comb begin
    for (int b = 0; b < MAX_CODE_BITS; b++) begin
      mask[b] = (32'(b) < 32'(look_len));
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit[i] = (len_r[i] != '0) && (CW'(len_r[i]) == CW'(look_len)) &&
               ((MAX_CODE_BITS'(code_r[i]) & mask) == (look_buf & mask));
    end
  end

  // isolate lowest set bit
  assign first = hit & (~hit + TABLE_DEPTH'(1));

  always_comb begin
    sym_sel = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sym_sel = sym_sel | (first[i] ? sym_r[i] : '0);
    end
  end

  assign match.hit    = |hit;
  assign match.symbol = sym_sel;

endmodule

### src/hbd_out_stage.sv
// ----------------------------------------------------------------------------
// hbd_out_stage
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module hbd_out_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  hbd_pkg::result_t                res,
  output logic                            adv,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_symbol_valid,
  output logic [hbd_pkg::SYM_W-1:0]       out_symbol,
  output logic                            out_error_mark,
  output logic [hbd_pkg::COUNT_W-1:0]     out_decoded_count
);
  import hbd_pkg::*;

  logic    valid_r;
  result_t res_r;

  // register is free when empty or being taken this cycle
  assign adv = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && load) begin
      res_r <= res;
    end
  end

  assign out_valid         = valid_r;
  assign out_symbol_valid  = res_r.symbol_valid;
  assign out_symbol        = res_r.symbol;
  assign out_error_mark    = res_r.error_mark;
  assign out_decoded_count = res_r.decoded_count;

endmodule

### src/huffman_bitstream_decoder_unit.sv
// A request waits in the input register and its result in the result register.
// Throughput: one request per cycle unless out_stall holds a full result
// register; the buffer update (shift, table compare, clear) is combinational.
// Reset: table entries empty, bit buffer, buffer length and decoded count zero,
// error length 16; no clearing pass, the block takes requests right away.
// ----------------------------------------------------------------------------
// huffman_bitstream_decoder_unit
// Prefix-code bitstream decoder with a loadable code table and error limit.
// ----------------------------------------------------------------------------
module huffman_bitstream_decoder_unit #(
  parameter int TABLE_DEPTH   = 64,
  parameter int MAX_CODE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [hbd_pkg::LEN_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hbd_pkg::KIND_W-1:0]      in_kind,
  input  logic [hbd_pkg::INDEX_W-1:0]     in_entry_index,
  input  logic [hbd_pkg::CODE_W-1:0]      in_entry_code,
  input  logic [hbd_pkg::LEN_W-1:0]       in_entry_length,
  input  logic [hbd_pkg::SYM_W-1:0]       in_entry_symbol,
  input  logic                            in_code_bit,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_symbol_valid,
  output logic [hbd_pkg::SYM_W-1:0]       out_symbol,
  output logic                            out_error_mark,
  output logic [hbd_pkg::COUNT_W-1:0]     out_decoded_count
);
  import hbd_pkg::*;

  localparam int LW = $clog2(MAX_CODE_BITS + 1);
  localparam int CW = (LW > LEN_W) ? LW : LEN_W;

  // input register
  logic               s1_valid_r;
  kind_t              s1_kind_r;
  logic [INDEX_W-1:0] s1_index_r;
  logic [CODE_W-1:0]  s1_code_r;
  logic [LEN_W-1:0]   s1_length_r;
  logic [SYM_W-1:0]   s1_symbol_r;
  logic               s1_bit_r;

  // decoder state
  logic [MAX_CODE_BITS-1:0] buf_r,     buf_nxt;
  logic [LW-1:0]            buf_len_r, buf_len_nxt;
  logic [COUNT_W-1:0]       cnt_r,     cnt_nxt;
  logic [LEN_W-1:0]         err_len_r;

  logic                     adv;
  logic                     fire;
  logic                     is_bit;
  logic                     in_range;
  logic                     tbl_we;
  logic [MAX_CODE_BITS-1:0] buf_shift;
  logic [LW-1:0]            len_inc;
  logic [CW-1:0]            limit;
  logic                     err_hit;
  logic                     res_load;
  match_t                   match;
  result_t                  res;

  assign in_stall = s1_valid_r && !adv;
  assign fire     = s1_valid_r && adv;
  assign is_bit   = (s1_kind_r == KIND_BIT);
  assign in_range = (32'(s1_index_r) < 32'(TABLE_DEPTH));
  assign tbl_we   = fire && !is_bit && in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_kind_r   <= kind_t'(in_kind);
      s1_index_r  <= in_entry_index;
      s1_code_r   <= in_entry_code;
      s1_length_r <= in_entry_length;
      s1_symbol_r <= in_entry_symbol;
      s1_bit_r    <= in_code_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_len_r <= ERR_LEN_RESET;
    end else if (cfg_we) begin
      err_len_r <= cfg_wdata;
    end
  end

  assign buf_shift = {buf_r[MAX_CODE_BITS-2:0], s1_bit_r};
  assign len_inc   = buf_len_r + LW'(1);

  // zero or oversized limit falls back to the full buffer width
  assign limit = ((err_len_r == '0) || (CW'(err_len_r) > CW'(MAX_CODE_BITS))) ?
                 CW'(MAX_CODE_BITS) : CW'(err_len_r);

  hbd_table #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (tbl_we),
    .wr_index  (s1_index_r),
    .wr_code   (s1_code_r),
    .wr_length (s1_length_r),
    .wr_symbol (s1_symbol_r),
    .look_buf  (buf_shift),
    .look_len  (len_inc),
    .match     (match)
  );

  assign err_hit = !match.hit && (CW'(len_inc) >= limit);

  always_comb begin
    buf_nxt     = buf_r;
    buf_len_nxt = buf_len_r;
    cnt_nxt     = cnt_r;
    if (fire && is_bit) begin
      if (match.hit) begin
        buf_nxt     = '0;
        buf_len_nxt = '0;
        cnt_nxt     = cnt_r + COUNT_W'(1);
      end else if (err_hit) begin
        buf_nxt     = '0;
        buf_len_nxt = '0;
      end else begin
        buf_nxt     = buf_shift;
        buf_len_nxt = len_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r     <= '0;
      buf_len_r <= '0;
      cnt_r     <= '0;
    end else begin
      buf_r     <= buf_nxt;
      buf_len_r <= buf_len_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  assign res_load          = fire && is_bit && (match.hit || err_hit);
  assign res.symbol_valid  = match.hit;
  assign res.symbol        = match.hit ? match.symbol : '0;
  assign res.error_mark    = !match.hit;
  assign res.decoded_count = cnt_nxt;

  hbd_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (res_load),
    .res               (res),
    .adv               (adv),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_symbol_valid  (out_symbol_valid),
    .out_symbol        (out_symbol),
    .out_error_mark    (out_error_mark),
    .out_decoded_count (out_decoded_count)
  );

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_symbol_valid ^ out_error_mark))
    else $error("result is neither exactly a symbol nor an error");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(buf_len_r) < CW'(MAX_CODE_BITS))
    else $error("bit buffer length reached the buffer width");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_bit && match.hit) |=> (cnt_r == $past(cnt_r) + COUNT_W'(1)))
    else $error("decoded count did not advance on a symbol");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the result register could move");

endmodule
